// ===== src/hbre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbre_pkg
// Types, codes and the CRC-8 step shared by the heater bus request engine.
// ----------------------------------------------------------------------------
package hbre_pkg;

    localparam int unsigned REQUEST_BYTES = 7;
    localparam int unsigned STEP_W        = $clog2(REQUEST_BYTES);

    localparam logic [7:0]  REQ_HEAD      = 8'h07;
    localparam logic [7:0]  REQ_TAIL      = 8'h05;
    localparam logic [7:0]  CRC_POLY      = 8'h18;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  BUFSIZE_RESET = 8'd32;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_RX   = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_REPLY = 2'd1,
        ST_SHORT    = 2'd2,
        ST_CRC_FAIL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    // What the result stage is currently emitting.
    typedef enum logic [1:0] {
        OUT_TX   = 2'd0,
        OUT_RX   = 2'd1,
        OUT_DONE = 2'd2
    } out_mode_t;

    typedef enum logic {
        REG_TIMEOUT = 1'b0,
        REG_BUFSIZE = 1'b1
    } reg_index_t;

    // One CRC-8 step: rotate left with xor of the polynomial when the top
    // bit is set, else shift left; then fold in the byte.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        begin
            if (crc[7])
            begin
                c = {crc[6:0], 1'b1} ^ CRC_POLY;
            end
            else
            begin
                c = {crc[6:0], 1'b0};
            end
            return c ^ b;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/heater_bus_request_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heater_bus_request_engine_unit
// Master side of a heater serial exchange: builds the CRC-8 protected
// request, then checks and forwards the length-prefixed reply.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tuser = func, tdata = request_code, param_number, rx_byte
// m_axis    out        tuser = kind, tlast = last,
//                      tdata = byte_value, byte_index, status, byte_count
// apb       in/out     timeout_ticks at 0x0, buffer_size at 0x4
//
// An input word is held in an input register and is processed in the cycle
// in which it moves into the result stage, so a new word is taken in every
// cycle while results flow freely. A start word yields seven result words,
// one per cycle while the receiver is ready; the input side stalls behind
// them. A received byte yields one or two words in an exchange, none while
// idle, and a tick at most one. The input register lets one word wait while
// the result stage still holds results. Reset (rst_n low, asynchronous)
// returns to idle and loads register defaults; no clearing pass is needed.
//
module heater_bus_request_engine_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] request_code, [15:8] param_number, [23:16] rx_byte
    input  wire logic [23:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] byte_value, [15:8] byte_index, [17:16] status, [25:18] byte_count,
    // [31:26] zero
    output logic [31:0]      m_axis_tdata,
    // [1:0] kind
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned STEP_W = hbre_pkg::STEP_W;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(hbre_pkg::REQUEST_BYTES - 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [15:0] timeout_reg;
    logic [7:0]  bufsize_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= hbre_pkg::TIMEOUT_RESET;
            bufsize_reg <= hbre_pkg::BUFSIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (hbre_pkg::reg_index_t'(paddr[2]))
                hbre_pkg::REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                hbre_pkg::REG_BUFSIZE: bufsize_reg <= pwdata[7:0];
                default:               timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (hbre_pkg::reg_index_t'(paddr[2]))
            hbre_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            hbre_pkg::REG_BUFSIZE: prdata = {24'd0, bufsize_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    hbre_pkg::func_t     in_func_reg;
    logic [7:0]          in_code_reg;
    logic [7:0]          in_param_reg;
    logic [7:0]          in_rx_reg;
    logic                in_move;
    logic                out_final_fire;

    logic                out_busy_reg;

    // The held word moves on when the result stage is empty or is handing
    // over its final word in this cycle.
    assign in_move       = in_valid_reg && (!out_busy_reg || out_final_fire);
    assign s_axis_tready = !in_valid_reg || in_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_func_reg  <= hbre_pkg::func_t'(s_axis_tuser);
            in_code_reg  <= s_axis_tdata[7:0];
            in_param_reg <= s_axis_tdata[15:8];
            in_rx_reg    <= s_axis_tdata[23:16];
        end
    end

    // ------------------------------------------------------------------
    // Exchange state.
    // ------------------------------------------------------------------
    hbre_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]          crc_reg, crc_next;
    logic [7:0]          flen_reg, flen_next;
    logic [7:0]          rcount_reg, rcount_next;
    logic [15:0]         timer_reg, timer_next;

    // Result stage load request from the processing logic.
    logic                load;
    hbre_pkg::out_mode_t load_mode;
    logic [7:0]          load_val;
    logic [7:0]          load_idx;
    logic                load_done;
    hbre_pkg::status_t   load_status;
    logic [7:0]          load_count;
    logic [7:0]          req_crc;

    logic [7:0]          len_clip;
    logic [7:0]          len_eff;
    logic [7:0]          rcount_inc;
    logic [15:0]         timer_inc;

    // CRC of the six fixed-layout request bytes.
    always_comb
    begin
        req_crc = hbre_pkg::crc8_next(8'd0, hbre_pkg::REQ_HEAD);
        req_crc = hbre_pkg::crc8_next(req_crc, 8'h00);
        req_crc = hbre_pkg::crc8_next(req_crc, in_code_reg);
        req_crc = hbre_pkg::crc8_next(req_crc, 8'h00);
        req_crc = hbre_pkg::crc8_next(req_crc, in_param_reg);
        req_crc = hbre_pkg::crc8_next(req_crc, hbre_pkg::REQ_TAIL);
    end

    // A length above the buffer size is clipped, and zero counts as one.
    always_comb
    begin
        len_clip = (in_rx_reg > bufsize_reg) ? bufsize_reg : in_rx_reg;
        if (len_clip == 8'd0)
        begin
            len_clip = 8'd1;
        end
    end

    assign len_eff    = (phase_reg == hbre_pkg::PH_LEN) ? len_clip : flen_reg;
    assign rcount_inc = rcount_reg + 8'd1;
    assign timer_inc  = (timer_reg == hbre_pkg::TIMER_MAX) ? timer_reg : timer_reg + 16'd1;

    // Next-state logic.
    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        flen_next   = flen_reg;
        rcount_next = rcount_reg;
        timer_next  = timer_reg;
        if (in_move)
        begin
            case (in_func_reg)
                hbre_pkg::FUNC_START:
                begin
                    phase_next  = hbre_pkg::PH_LEN;
                    crc_next    = 8'd0;
                    flen_next   = 8'd0;
                    rcount_next = 8'd0;
                    timer_next  = 16'd0;
                end
                hbre_pkg::FUNC_BYTE:
                begin
                    if (phase_reg != hbre_pkg::PH_IDLE)
                    begin
                        flen_next   = len_eff;
                        rcount_next = rcount_inc;
                        timer_next  = 16'd0;
                        if (rcount_inc >= len_eff)
                        begin
                            phase_next = hbre_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = hbre_pkg::PH_RECV;
                            crc_next   = hbre_pkg::crc8_next(crc_reg, in_rx_reg);
                        end
                    end
                end
                hbre_pkg::FUNC_TICK:
                begin
                    if (phase_reg != hbre_pkg::PH_IDLE)
                    begin
                        timer_next = timer_inc;
                        if (timer_inc >= timeout_reg)
                        begin
                            phase_next = hbre_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Output logic: what the processed word hands to the result stage.
    always_comb
    begin
        load        = 1'b0;
        load_mode   = hbre_pkg::OUT_TX;
        load_val    = in_code_reg;
        load_idx    = rcount_reg;
        load_done   = 1'b0;
        load_status = hbre_pkg::ST_OK;
        load_count  = rcount_inc;
        if (in_move)
        begin
            case (in_func_reg)
                hbre_pkg::FUNC_START:
                begin
                    load = 1'b1;
                end
                hbre_pkg::FUNC_BYTE:
                begin
                    if (phase_reg != hbre_pkg::PH_IDLE)
                    begin
                        load      = 1'b1;
                        load_mode = hbre_pkg::OUT_RX;
                        load_val  = in_rx_reg;
                        if (rcount_inc >= len_eff)
                        begin
                            load_done   = 1'b1;
                            load_status = (crc_reg == in_rx_reg) ? hbre_pkg::ST_OK
                                                                 : hbre_pkg::ST_CRC_FAIL;
                        end
                    end
                end
                hbre_pkg::FUNC_TICK:
                begin
                    if (phase_reg != hbre_pkg::PH_IDLE && timer_inc >= timeout_reg)
                    begin
                        load        = 1'b1;
                        load_mode   = hbre_pkg::OUT_DONE;
                        load_done   = 1'b1;
                        load_count  = rcount_reg;
                        load_status = (phase_reg == hbre_pkg::PH_LEN) ? hbre_pkg::ST_NO_REPLY
                                                                      : hbre_pkg::ST_SHORT;
                    end
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hbre_pkg::PH_IDLE;
            crc_reg    <= 8'd0;
            flen_reg   <= 8'd0;
            rcount_reg <= 8'd0;
            timer_reg  <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            flen_reg   <= flen_next;
            rcount_reg <= rcount_next;
            timer_reg  <= timer_next;
        end
    end

    // ------------------------------------------------------------------
    // Result stage. A request is replayed from its code, parameter and
    // CRC by a step counter; a received byte is followed by an optional
    // done word, and a timeout yields a lone done word.
    // ------------------------------------------------------------------
    hbre_pkg::out_mode_t mode_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [7:0]          val_reg;
    logic [7:0]          param_reg;
    logic [7:0]          rcrc_reg;
    logic [7:0]          idx_reg;
    logic                done_reg;
    hbre_pkg::status_t   status_reg;
    logic [7:0]          count_reg;

    hbre_pkg::kind_t     o_kind;
    logic [7:0]          o_val;
    logic [7:0]          o_idx;
    hbre_pkg::status_t   o_status;
    logic [7:0]          o_count;
    logic                o_last;
    logic                out_fire;

    always_comb
    begin
        o_kind   = hbre_pkg::KIND_TX;
        o_val    = 8'd0;
        o_idx    = 8'd0;
        o_status = hbre_pkg::ST_OK;
        o_count  = 8'd0;
        o_last   = 1'b1;
        case (mode_reg)
            hbre_pkg::OUT_TX:
            begin
                o_idx  = 8'(step_reg);
                o_last = (step_reg == STEP_LAST);
                case (step_reg)
                    STEP_W'(0): o_val = hbre_pkg::REQ_HEAD;
                    STEP_W'(2): o_val = val_reg;
                    STEP_W'(4): o_val = param_reg;
                    STEP_W'(5): o_val = hbre_pkg::REQ_TAIL;
                    STEP_W'(6): o_val = rcrc_reg;
                    default:    o_val = 8'h00;
                endcase
            end
            hbre_pkg::OUT_RX:
            begin
                if (step_reg == STEP_W'(0))
                begin
                    o_kind = hbre_pkg::KIND_RX;
                    o_val  = val_reg;
                    o_idx  = idx_reg;
                    o_last = !done_reg;
                end
                else
                begin
                    o_kind   = hbre_pkg::KIND_DONE;
                    o_status = status_reg;
                    o_count  = count_reg;
                end
            end
            default:
            begin
                o_kind   = hbre_pkg::KIND_DONE;
                o_status = status_reg;
                o_count  = count_reg;
            end
        endcase
    end

    assign out_fire       = out_busy_reg && m_axis_tready;
    assign out_final_fire = out_fire && o_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            step_reg     <= '0;
        end
        else if (load)
        begin
            out_busy_reg <= 1'b1;
            step_reg     <= '0;
        end
        else if (out_final_fire)
        begin
            out_busy_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg   <= load_mode;
            val_reg    <= load_val;
            param_reg  <= in_param_reg;
            rcrc_reg   <= req_crc;
            idx_reg    <= load_idx;
            done_reg   <= load_done;
            status_reg <= load_status;
            count_reg  <= load_count;
        end
    end

    assign m_axis_tvalid = out_busy_reg;
    assign m_axis_tuser  = o_kind;
    assign m_axis_tlast  = o_last;
    assign m_axis_tdata  = {6'd0, o_count, o_status, o_idx, o_val};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == hbre_pkg::KIND_DONE) |-> m_axis_tlast)
        else $error("done word without last");

    a_tx_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == hbre_pkg::KIND_TX && m_axis_tlast)
        |-> (m_axis_tdata[15:8] == 8'(hbre_pkg::REQUEST_BYTES - 1)))
        else $error("request ended at wrong index");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_final_fire && !load) |=> !m_axis_tvalid)
        else $error("result stage kept running after final word");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_busy_reg))
        else $error("input stalled without cause");

    a_idle_no_load_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_move && in_func_reg == hbre_pkg::FUNC_BYTE && phase_reg == hbre_pkg::PH_IDLE)
        |=> !m_axis_tvalid)
        else $error("byte while idle produced a result");

endmodule
`default_nettype wire

// ===== bench/heater_bus_request_engine_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_bus_request_engine_unit_test
// Self-checking bench for the heater bus request engine. Line events (start,
// received byte, timer tick) are queued by the main sequence, fed into the
// input stream by a clocked driver and run through a cycle-free model of the
// exchange at the moment they are accepted. A clocked monitor compares every
// result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module heater_bus_request_engine_unit_test;

    // One queued line event, as it travels on the input stream.
    typedef struct {
        hbre_pkg::func_t func;
        logic [7:0]      code;
        logic [7:0]      param;
        logic [7:0]      rx;
        bit              hold;    // wait until every predicted word has come out
    } line_event_t;

    // One predicted result word.
    typedef struct {
        hbre_pkg::kind_t   kind;
        logic [7:0]        value;
        logic [7:0]        index;
        hbre_pkg::status_t status;
        logic [7:0]        count;
        logic              last;
    } bus_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] request_code, [15:8] param_number, [23:16] rx_byte
    logic [23:0] s_axis_tdata = '0;
    // [1:0] func
    logic [1:0]  s_axis_tuser = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] byte_value, [15:8] byte_index, [17:16] status, [25:18] byte_count
    logic [31:0] m_axis_tdata;
    // [1:0] kind
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Events waiting to be driven, and result words that the model says are due.
    line_event_t line_events [$];
    bus_word_t   due_words [$];

    int unsigned mismatch_count = 0;
    int unsigned queued_count = 0;
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 61;
    bit          hold_next = 1'b0;

    // Model copy of the registers and of the exchange state.
    logic [15:0]      cfg_timeout = hbre_pkg::TIMEOUT_RESET;
    logic [7:0]       cfg_bufsize = hbre_pkg::BUFSIZE_RESET;
    hbre_pkg::phase_t model_phase = hbre_pkg::PH_IDLE;
    logic [7:0]       model_crc = '0;
    logic [7:0]       model_frame_len = '0;
    logic [7:0]       model_rx_count = '0;
    logic [15:0]      model_timer = '0;

    heater_bus_request_engine_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The checksum step: a rotate left, which brings bit 7 down into bit 0,
    // folds in the polynomial only when that bit was set; then the byte.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        return {crc[6:0], crc[7]} ^ (crc[7] ? hbre_pkg::CRC_POLY : 8'h00) ^ data;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic owe_word(input hbre_pkg::kind_t kind, input logic [7:0] value,
                            input logic [7:0] index, input hbre_pkg::status_t status,
                            input logic [7:0] count, input logic last);
        bus_word_t w;
        w.kind   = kind;
        w.value  = value;
        w.index  = index;
        w.status = status;
        w.count  = count;
        w.last   = last;
        due_words.push_back(w);
    endtask

    // Advances the model by one accepted input word and queues the result
    // words it causes.
    task automatic predict_exchange_step(input hbre_pkg::func_t func, input logic [7:0] code,
                                         input logic [7:0] param, input logic [7:0] rx);
        logic [7:0] request [hbre_pkg::REQUEST_BYTES];
        logic [7:0] crc;
        logic [7:0] slot;
        logic [7:0] len;
        case (func)
            hbre_pkg::FUNC_START:
            begin
                // A start always wins, even over an exchange in progress.
                request[0] = hbre_pkg::REQ_HEAD;
                request[1] = 8'h00;
                request[2] = code;
                request[3] = 8'h00;
                request[4] = param;
                request[5] = hbre_pkg::REQ_TAIL;
                crc = 8'h00;
                for (int i = 0; i < hbre_pkg::REQUEST_BYTES - 1; i++)
                begin
                    crc = crc_step(crc, request[i]);
                end
                request[hbre_pkg::REQUEST_BYTES - 1] = crc;
                for (int i = 0; i < hbre_pkg::REQUEST_BYTES; i++)
                begin
                    owe_word(hbre_pkg::KIND_TX, request[i], 8'(i), hbre_pkg::ST_OK, 8'h00,
                             i == hbre_pkg::REQUEST_BYTES - 1);
                end
                model_phase     = hbre_pkg::PH_LEN;
                model_crc       = 8'h00;
                model_frame_len = 8'h00;
                model_rx_count  = 8'h00;
                model_timer     = 16'h0000;
            end
            hbre_pkg::FUNC_BYTE:
            begin
                if (model_phase != hbre_pkg::PH_IDLE)
                begin
                    if (model_phase == hbre_pkg::PH_LEN)
                    begin
                        // The length byte is clipped to the buffer, and zero means one.
                        len = (rx > cfg_bufsize) ? cfg_bufsize : rx;
                        if (len == 8'h00)
                        begin
                            len = 8'h01;
                        end
                        model_frame_len = len;
                        model_phase     = hbre_pkg::PH_RECV;
                    end
                    slot = model_rx_count;
                    model_rx_count = model_rx_count + 8'h01;
                    model_timer = 16'h0000;
                    if (model_rx_count >= model_frame_len)
                    begin
                        owe_word(hbre_pkg::KIND_RX, rx, slot, hbre_pkg::ST_OK, 8'h00, 1'b0);
                        owe_word(hbre_pkg::KIND_DONE, 8'h00, 8'h00,
                                 (model_crc == rx) ? hbre_pkg::ST_OK : hbre_pkg::ST_CRC_FAIL,
                                 model_rx_count, 1'b1);
                        model_phase = hbre_pkg::PH_IDLE;
                    end
                    else
                    begin
                        model_crc = crc_step(model_crc, rx);
                        owe_word(hbre_pkg::KIND_RX, rx, slot, hbre_pkg::ST_OK, 8'h00, 1'b1);
                    end
                end
            end
            hbre_pkg::FUNC_TICK:
            begin
                if (model_phase != hbre_pkg::PH_IDLE)
                begin
                    if (model_timer != hbre_pkg::TIMER_MAX)
                    begin
                        model_timer = model_timer + 16'h0001;
                    end
                    if (model_timer >= cfg_timeout)
                    begin
                        owe_word(hbre_pkg::KIND_DONE, 8'h00, 8'h00,
                                 (model_phase == hbre_pkg::PH_LEN) ? hbre_pkg::ST_NO_REPLY
                                                                   : hbre_pkg::ST_SHORT,
                                 model_rx_count, 1'b1);
                        model_phase = hbre_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                // The unused code has no effect at all.
            end
        endcase
    endtask

    // Compares the word on the output stream with the oldest prediction.
    task automatic check_result();
        bus_word_t want;
        if (due_words.size() == 0)
        begin
            report_mismatch("result word with none due", m_axis_tdata, 32'h0);
        end
        else
        begin
            want = due_words.pop_front();
            if (m_axis_tuser !== want.kind)
                report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
            if (m_axis_tdata[7:0] !== want.value)
                report_mismatch("byte_value", 32'(m_axis_tdata[7:0]), 32'(want.value));
            if (m_axis_tdata[15:8] !== want.index)
                report_mismatch("byte_index", 32'(m_axis_tdata[15:8]), 32'(want.index));
            if (m_axis_tdata[17:16] !== want.status)
                report_mismatch("status", 32'(m_axis_tdata[17:16]), 32'(want.status));
            if (m_axis_tdata[25:18] !== want.count)
                report_mismatch("byte_count", 32'(m_axis_tdata[25:18]), 32'(want.count));
            if (m_axis_tlast !== want.last)
                report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        end
    endtask

    // Driver. The word on the bus is predicted at the edge that accepts it;
    // a new word is put up only once the old one is gone, so tvalid changes
    // at most once per edge. A held event stays back until every predicted
    // word has been received.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_exchange_step(hbre_pkg::func_t'(s_axis_tuser), s_axis_tdata[7:0],
                                      s_axis_tdata[15:8], s_axis_tdata[23:16]);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (line_events.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(line_events[0].hold && due_words.size() != 0))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= line_events[0].func;
                    s_axis_tdata  <= {line_events[0].rx, line_events[0].param,
                                      line_events[0].code};
                    void'(line_events.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Checks every accepted result word and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_item(input hbre_pkg::func_t func, input logic [7:0] code,
                              input logic [7:0] param, input logic [7:0] rx);
        line_event_t ev;
        ev.func  = func;
        ev.code  = code;
        ev.param = param;
        ev.rx    = rx;
        ev.hold  = hold_next || ($urandom_range(39) == 0);
        hold_next = 1'b0;
        line_events.push_back(ev);
        queued_count++;
    endtask

    task automatic queue_start();
        queue_item(hbre_pkg::FUNC_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    endtask

    task automatic queue_byte(input logic [7:0] rx);
        queue_item(hbre_pkg::FUNC_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)), rx);
    endtask

    task automatic queue_tick();
        queue_item(hbre_pkg::FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    endtask

    // Noise words: mostly the unused function code, which is always ignored.
    task automatic queue_noise(input bit any_func);
        line_event_t ev;
        ev.func  = any_func ? hbre_pkg::func_t'($urandom_range(1, 3)) : hbre_pkg::FUNC_NONE;
        ev.code  = 8'($urandom_range(255));
        ev.param = 8'($urandom_range(255));
        ev.rx    = 8'($urandom_range(255));
        ev.hold  = 1'b0;
        line_events.push_back(ev);
        queued_count++;
    endtask

    // One request and its reply under the current register values. The
    // reply is well formed unless the exchange is cut short (by a timeout,
    // or by simply leaving it for the next start) or gets a bad checksum.
    task automatic queue_exchange(input bit complete);
        logic [7:0]  len_byte;
        logic [7:0]  crc;
        logic [7:0]  value;
        int unsigned frame_len;
        int unsigned max_len;
        int unsigned cut_at;
        int unsigned mode;
        int unsigned gap_max;
        bit          cut;
        // Gaps between reply bytes stay below the timeout.
        gap_max = (cfg_timeout >= 16'd2)
                  ? ((cfg_timeout > 16'd4) ? 32'd3 : 32'(cfg_timeout) - 32'd1) : 32'd0;
        max_len = (cfg_bufsize < 8'd10) ? 32'(cfg_bufsize) + 32'd2 : 32'd12;
        // Long length bytes only where the buffer clips them to a short frame.
        if (cfg_bufsize < 8'd32 && $urandom_range(9) == 0)
            len_byte = 8'($urandom_range(255));
        else
            len_byte = 8'($urandom_range(max_len));
        frame_len = (len_byte > cfg_bufsize) ? 32'(cfg_bufsize) : 32'(len_byte);
        if (frame_len == 0)
            frame_len = 1;
        mode = complete ? 9 : $urandom_range(9);
        if (mode == 0 && cfg_timeout > 24)
            mode = 1;
        cut_at = $urandom_range(frame_len - 1);
        cut = 1'b0;
        queue_start();
        crc = 8'h00;
        for (int i = 0; i < frame_len && !cut; i++)
        begin
            if (mode <= 1 && i == cut_at)
            begin
                cut = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(gap_max)) queue_tick();
                if ($urandom_range(14) == 0)
                    queue_noise(1'b0);
                if (i == 0)
                    value = len_byte;
                else if (i == frame_len - 1)
                    value = (mode == 2) ? crc ^ 8'($urandom_range(1, 255)) : crc;
                else
                    value = 8'($urandom_range(255));
                queue_byte(value);
                crc = crc_step(crc, value);
            end
        end
        if (mode == 0)
        begin
            repeat ((cfg_timeout == 0) ? 1 : int'(cfg_timeout)) queue_tick();
        end
    endtask

    task automatic write_register(input hbre_pkg::reg_index_t idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] mask;
        mask = (idx == hbre_pkg::REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == hbre_pkg::REG_TIMEOUT)
            cfg_timeout = value[15:0];
        else
            cfg_bufsize = value[7:0];
        // Read it back through the same port.
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((readback & mask) !== (value & mask))
            report_mismatch("register readback", readback, value & mask);
    endtask

    task automatic set_config(input logic [15:0] timeout, input logic [7:0] bufsize);
        write_register(hbre_pkg::REG_TIMEOUT, 32'(timeout));
        write_register(hbre_pkg::REG_BUFSIZE, 32'(bufsize));
    endtask

    // Waits until the block has drained and then a little longer, since a
    // tick that causes nothing may still sit in the input register.
    task automatic wait_idle();
        @(negedge clk);
        while (line_events.size() != 0 || s_axis_tvalid || due_words.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset register values. Bytes, ticks and the
        // unused code while idle come first and must cause nothing.
        queue_item(hbre_pkg::FUNC_BYTE, 8'hFF, 8'hFF, 8'hFF);
        queue_item(hbre_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00);
        queue_item(hbre_pkg::FUNC_NONE, 8'hFF, 8'hFF, 8'hFF);
        queue_item(hbre_pkg::FUNC_START, 8'h00, 8'h00, 8'h00);
        // A second start drops the exchange in progress.
        queue_item(hbre_pkg::FUNC_START, 8'hFF, 8'hFF, 8'h00);
        // A zero length makes a one-byte frame checked against an empty CRC.
        queue_byte(8'h00);
        queue_item(hbre_pkg::FUNC_START, 8'hA5, 8'h5A, 8'h00);
        queue_byte(8'd3);
        queue_tick();
        queue_item(hbre_pkg::FUNC_NONE, 8'h00, 8'h00, 8'h00);
        queue_byte(8'hC3);
        queue_byte(crc_step(crc_step(8'h00, 8'd3), 8'hC3));
        queue_item(hbre_pkg::FUNC_START, 8'h12, 8'h34, 8'h00);
        queue_byte(8'd2);
        queue_byte(~crc_step(8'h00, 8'd2));
        wait_idle();

        // Short timeout and a tiny buffer: length clipping, then both kinds
        // of timeout. The second start waits until the bus has drained.
        set_config(16'd2, 8'd3);
        queue_start();
        queue_byte(8'hFF);
        queue_byte(8'h3C);
        queue_byte(crc_step(crc_step(8'h00, 8'hFF), 8'h3C));
        hold_next = 1'b1;
        queue_start();
        queue_tick();
        queue_tick();
        queue_start();
        queue_byte(8'd5);
        queue_tick();
        queue_tick();
        wait_idle();

        // Random part: several register settings, the extremes among them.
        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 27 : (p < 4) ? 61 : 0;
            recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 27 : 0;
            case (p)
                0: set_config(16'd3, 8'd8);
                1: set_config(16'd1, 8'd1);
                2: set_config(16'd0, 8'd0);
                3: set_config(16'hFFFF, 8'd255);
                4: set_config(16'd7, 8'd16);
                default: set_config(16'd20, 8'd5);
            endcase
            queued_count = 0;
            while (queued_count < 24)
            begin
                if ($urandom_range(3) == 0)
                    queue_noise($urandom_range(1) == 1);
                queue_exchange(1'b0);
            end
            // Finish on a whole exchange so the block is idle for the next write.
            queue_exchange(1'b1);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a block that stops accepting or producing words.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hbre_pkg.sv
src/heater_bus_request_engine_unit.sv
bench/heater_bus_request_engine_unit_test.sv
